[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the decimal text converter.
// Every module that uses them has i_clk and an active-low reset i_rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ITDS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ITDS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/itds_pkg.sv]
// ---------------------------------------------------------------------------
// itds_pkg
// Types and constants of the integer to decimal text converter.
// ---------------------------------------------------------------------------
`default_nettype none

package itds_pkg;

    localparam int NUM_DIGITS  = 5;
    localparam int QUEUE_DEPTH = 2;

    // Characters, already cut to the six low bits of their ASCII codes.
    localparam logic [5:0] CH_SPACE = 6'h20;
    localparam logic [5:0] CH_MINUS = 6'h2D;
    localparam logic [5:0] CH_POINT = 6'h2E;
    localparam logic [5:0] CH_ZERO  = 6'h30;

    localparam logic [3:0] MAX_DECIMALS = 4'd8;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x.
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    // Configuration register indexes.
    localparam logic [7:0] CFG_SIGNED_MODE    = 8'd0;
    localparam logic [7:0] CFG_DECIMAL_PLACES = 8'd1;
    localparam logic [7:0] CFG_SIGN_SPACE     = 8'd2;

    // Leading sign codes.
    localparam logic [1:0] SGN_NONE  = 2'd0;
    localparam logic [1:0] SGN_MINUS = 2'd1;
    localparam logic [1:0] SGN_SPACE = 2'd2;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic       signed_mode;
        logic [3:0] decimal_places;
        logic       sign_space;
    } t_cfg;

    // One converted number, waiting to be printed.
    typedef struct packed {
        logic [1:0]                   sign;
        t_digit [NUM_DIGITS-1:0]      digits;  // digit 0 is the least significant
        logic [3:0]                   top;     // index of the first printed digit
        logic [3:0]                   dec;     // saturated decimal places
    } t_entry;

endpackage

`default_nettype wire

[rtl/itds_front.sv]
// ---------------------------------------------------------------------------
// itds_front
// Accepts a value, resolves its sign and extracts its decimal digits, one
// digit per cycle, then hands the result to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module itds_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire itds_pkg::t_cfg  i_cfg,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [15:0]     i_value,
    input  wire logic            i_full,
    output logic                 o_push,
    output itds_pkg::t_entry     o_entry
);
    import itds_pkg::*;

    localparam logic FS_IDLE = 1'b0;
    localparam logic FS_CONV = 1'b1;

    logic                    r_state, n_state;
    logic [15:0]             r_mag;
    logic [2:0]              r_nd;
    t_digit [NUM_DIGITS-1:0] r_dig;
    logic [1:0]              r_sign;
    logic [3:0]              r_dec;

    logic        w_neg;
    logic [15:0] w_mag;
    logic [31:0] w_prod;
    logic [15:0] w_quot;
    logic [15:0] w_prod10;
    logic [15:0] w_diff;
    logic        w_done;
    logic        w_take;

    assign w_neg = i_cfg.signed_mode & i_value[15];
    assign w_mag = w_neg ? 16'(~i_value + 16'd1) : i_value;

    assign w_prod   = {16'b0, r_mag} * {16'b0, DIV10_MUL};
    assign w_quot   = 16'(w_prod >> DIV10_SHIFT);
    assign w_prod10 = 16'({w_quot, 3'b000} + {w_quot, 1'b0});
    assign w_diff   = r_mag - w_prod10;

    assign w_done = (r_mag == 16'd0) || (r_nd == 3'(NUM_DIGITS));
    assign w_take = (r_state == FS_IDLE) && start;
    assign o_push = (r_state == FS_CONV) && w_done && !i_full;
    assign busy   = (r_state != FS_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (start) n_state = FS_CONV;
            FS_CONV: if (o_push) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mag  <= w_mag;
            r_nd   <= 3'd0;
            r_dig  <= '0;
            r_dec  <= (i_cfg.decimal_places > MAX_DECIMALS) ? MAX_DECIMALS
                                                            : i_cfg.decimal_places;
            if (w_neg) begin
                r_sign <= SGN_MINUS;
            end else if (i_cfg.signed_mode && i_cfg.sign_space) begin
                r_sign <= SGN_SPACE;
            end else begin
                r_sign <= SGN_NONE;
            end
        end else if ((r_state == FS_CONV) && !w_done) begin
            r_dig[r_nd] <= w_diff[3:0];
            r_mag       <= w_quot;
            r_nd        <= r_nd + 3'd1;
        end
    end

    // The printed digit run starts at the higher of the last real digit and
    // the decimal point position, so small values get their leading zeros.
    always_comb begin
        o_entry.sign   = r_sign;
        o_entry.digits = r_dig;
        o_entry.dec    = r_dec;
        o_entry.top    = ({1'b0, r_nd} > r_dec) ? ({1'b0, r_nd} - 4'd1) : r_dec;
    end

endmodule

`default_nettype wire

[rtl/itds_queue.sv]
// ---------------------------------------------------------------------------
// itds_queue
// Short queue of converted numbers between the converter and the printer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module itds_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire itds_pkg::t_entry i_entry,
    output logic                  o_full,
    input  wire logic             i_pop,
    output itds_pkg::t_entry      o_entry,
    output logic                  o_empty
);
    import itds_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ITDS_ASSERT(a_no_push_full, !(i_push && o_full), "push into a full queue")
    `ITDS_ASSERT(a_no_pop_empty, !(i_pop && o_empty), "pop from an empty queue")
    `ITDS_ASSERT(a_count_range, (r_count <= CNT_W'(QUEUE_DEPTH)), "queue count overflow")

endmodule

`default_nettype wire

[rtl/itds_back.sv]
// ---------------------------------------------------------------------------
// itds_back
// Prints one queued number as text, one character per cycle: optional sign,
// digits from the top index down to zero, the point after digit dec if dec > 0.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module itds_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire itds_pkg::t_entry i_entry,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_strobe,
    output logic [5:0]            o_character,
    output logic                  o_last
);
    import itds_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_POINT = 2'd3;

    logic [1:0]              r_phase, n_phase;
    logic [3:0]              r_pos, n_pos;
    t_digit [NUM_DIGITS-1:0] r_dig;
    logic [3:0]              r_dec;
    logic [1:0]              r_sign;
    logic                    r_strobe;
    logic [5:0]              r_char;
    logic                    r_last;

    t_digit     w_digit;
    logic [5:0] w_char;
    logic       w_last;

    // Digits above the extracted ones are padding zeros.
    assign w_digit = (r_pos < 4'(NUM_DIGITS)) ? r_dig[r_pos[2:0]] : t_digit'(0);
    assign w_last  = (r_phase == PH_DIGIT) && (r_pos == 4'd0);
    assign o_pop   = ((r_phase == PH_IDLE) || w_last) && !i_empty;

    always_comb begin
        unique case (r_phase)
            PH_SIGN:  w_char = (r_sign == SGN_MINUS) ? CH_MINUS : CH_SPACE;
            PH_DIGIT: w_char = CH_ZERO | {2'b00, w_digit};
            PH_POINT: w_char = CH_POINT;
            default:  w_char = CH_ZERO;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        if (o_pop) begin
            n_phase = (i_entry.sign != SGN_NONE) ? PH_SIGN : PH_DIGIT;
            n_pos   = i_entry.top;
        end else begin
            unique case (r_phase)
                PH_SIGN: n_phase = PH_DIGIT;
                PH_DIGIT: begin
                    if ((r_pos == r_dec) && (r_dec != 4'd0)) begin
                        n_phase = PH_POINT;
                    end else if (r_pos == 4'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_pos = r_pos - 4'd1;
                    end
                end
                PH_POINT: begin
                    n_phase = PH_DIGIT;
                    n_pos   = r_pos - 4'd1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_strobe <= (r_phase != PH_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_char <= w_char;
        r_last <= w_last;
        if (o_pop) begin
            r_dig  <= i_entry.digits;
            r_dec  <= i_entry.dec;
            r_sign <= i_entry.sign;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

    `ITDS_ASSERT(a_point_not_last, ((r_phase != PH_POINT) || (r_pos != 4'd0)),
                 "point phase reached digit zero")
    `ITDS_ASSERT(a_pos_range, ((r_phase == PH_IDLE) || (r_pos <= MAX_DECIMALS)),
                 "digit position out of range")
    `ITDS_ASSERT_NEXT(a_point_then_digit, (o_strobe && (o_character == CH_POINT)),
                      (o_strobe && (o_character != CH_POINT) && (o_character != CH_MINUS)),
                      "point not followed by a digit")

endmodule

`default_nettype wire

[rtl/integer_to_decimal_string.sv]
// ---------------------------------------------------------------------------
// integer_to_decimal_string
// Turns a 16-bit value into decimal ASCII text, one character per beat.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with i_value; the value is taken at a clock edge where busy
//   is low. Characters leave on o_character with o_strobe high for exactly
//   one cycle each; o_last marks the final character of a string. The
//   receiver cannot stall the output.
//   Configuration beats (i_cfg_valid, i_cfg_index, i_cfg_data) are always
//   taken; write them only while no string is being converted or printed.
//   Index 0 is signed mode, 1 the decimal places (saturated at eight), 2 the
//   sign space option; other indexes are ignored.
// Timing:
//   The converter peels off one decimal digit per cycle, so busy stays high
//   while the digits are extracted and the result is pushed, longer only
//   while the two-entry queue to the printer is full. The printer emits one
//   character per cycle, back to back across strings when the next one is
//   already queued; each character leaves through an output register after
//   the printer pops the string from the queue.
// Reset:
//   Synchronous, active low. Clears the queue and both controllers and
//   restores signed mode, no decimals and no sign space.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_decimal_string (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_value,
    output logic             o_strobe,
    output logic [5:0]       o_character,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import itds_pkg::*;

    t_cfg   r_cfg;
    t_entry w_push_entry;
    t_entry w_head;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.signed_mode    <= 1'b1;
            r_cfg.decimal_places <= 4'd0;
            r_cfg.sign_space     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SIGNED_MODE:    r_cfg.signed_mode    <= i_cfg_data[0];
                CFG_DECIMAL_PLACES: r_cfg.decimal_places <= i_cfg_data[3:0];
                CFG_SIGN_SPACE:     r_cfg.sign_space     <= i_cfg_data[0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    itds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .start   (start),
        .busy    (busy),
        .i_value (i_value),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    itds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_empty (w_empty)
    );

    itds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
